### src/lqs_pkg.sv
// Shared types and constants for the linear queue with search.
// Used by linear_queue_with_search and its testbench; depends on nothing.
`default_nettype none
package lqs_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = 5;
    localparam int CAP_W   = 5;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 5;
    localparam int OUT_W   = 1 + POS_W + CNT_W + WORD_W + WORD_W;
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
    localparam logic [POS_W-1:0]  POS_NONE  = {POS_W{1'b1}};
    localparam logic [WORD_W-1:0] WORD_NONE = {WORD_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_FIND  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HEAD,
        S_TAIL,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### src/lqs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module lqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                                          i_clk,
    input  wire                                          i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]                              i_wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/linear_queue_with_search.sv
// Top level of the linear (non-circular) array queue with search.
// Depends on lqs_pkg and lqs_ram.
//
//  channel  | dir | handshake                          | payload
//  ---------+-----+------------------------------------+---------------------------------
//  s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready  | tdata: value; tuser: mode
//  m_axis   | out | o_m_axis_tvalid / i_m_axis_tready  | tdata: ok,position,count,head,tail
//  cfg      | in  | i_cfg_we (no wait)                 | i_cfg_wdata: capacity
//
// Push, pop and clear pass from acceptance through S_HEAD, S_TAIL and S_DONE, where
// the result is loaded into the output register; find on a nonempty queue passes
// through S_SCAN first, comparing n entries (at most count, up to 16). A new word is
// accepted only in S_IDLE. The scan does one slot read and one 32-bit compare per cycle
// on the single RAM read port, which also serves the head and tail reads afterwards.
// Synchronous active-low reset empties the queue and sets capacity to 16; slot
// contents are not cleared. A stalled output holds its word; the next word is
// accepted meanwhile and waits in the final state for the output register.
`default_nettype none
module linear_queue_with_search
    import lqs_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // slave side
    input  wire                 i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  wire  [WORD_W-1:0]   i_s_axis_tdata,   // [31:0] value
    input  wire  [7:0]          i_s_axis_tuser,   // [1:0] mode, rest zero
    // master side
    output logic                o_m_axis_tvalid,
    input  wire                 i_m_axis_tready,
    output logic [TDATA_W-1:0]  o_m_axis_tdata,   // [0] ok, [5:1] position,
                                                  // [10:6] count, [42:11] head_value,
                                                  // [74:43] tail_value, rest zero
    // configuration
    input  wire                 i_cfg_we,
    input  wire  [CAP_W-1:0]    i_cfg_wdata       // capacity
);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CAP_W-1:0]    r_capacity;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [IDX_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ok, n_ok;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [WORD_W-1:0]   r_key, n_key;
    logic [IDX_W-1:0]    r_scan, n_scan;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic                r_cmp_valid, n_cmp_valid;
    logic [WORD_W-1:0]   r_head_val, n_head_val;
    logic                r_out_valid, n_out_valid;
    logic [TDATA_W-1:0]  r_out_data, n_out_data;

    // RAM control
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic                in_fire;
    logic                out_free;
    logic                load_out;
    logic                empty;
    logic [CNT_W-1:0]    cap_eff;
    logic                push_room;
    logic                cmp_hit;
    logic                cmp_last;
    t_mode               in_mode;

    assign in_mode  = t_mode'(i_s_axis_tuser[1:0]);
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign empty    = (r_count == '0);

    // capacity above the storage depth acts as the depth
    assign cap_eff  = (CNT_W'(r_capacity) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                           : CNT_W'(r_capacity);
    // room if the next slot (0 when empty, else tail + 1) lies below the effective capacity
    assign push_room = empty ? (cap_eff != '0)
                             : ((CNT_W'(r_tail) + CNT_W'(1)) < cap_eff);

    assign cmp_hit  = r_cmp_valid && (ram_rdata == r_key);
    assign cmp_last = r_cmp_valid && (r_cmp_idx == r_tail);

    lqs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    // find on a nonempty queue scans, everything else goes to readout
                    if (in_mode == MODE_FIND && !empty) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_HEAD;
                    end
                end
            end
            S_SCAN: begin
                if (cmp_hit || cmp_last) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: n_state = S_TAIL;
            S_TAIL: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb begin
        o_s_axis_tready = 1'b0;
        ram_raddr       = r_tail;
        load_out        = 1'b0;
        unique case (r_state)
            S_IDLE: o_s_axis_tready = 1'b1;
            S_SCAN: ram_raddr = r_scan;
            S_HEAD: ram_raddr = r_head;
            S_TAIL: ram_raddr = r_tail;
            S_DONE: begin
                // keep reading the tail so its data holds through a stall
                ram_raddr = r_tail;
                load_out  = out_free;
            end
            default: ram_raddr = r_tail;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_ok        = r_ok;
        n_pos       = r_pos;
        n_key       = r_key;
        n_scan      = r_scan;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_valid = r_cmp_valid;
        n_head_val  = r_head_val;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = empty ? '0 : (r_tail + IDX_W'(1));

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (in_fire) begin
            n_ok        = 1'b0;
            n_pos       = POS_NONE;
            n_key       = i_s_axis_tdata;
            n_scan      = r_head;
            n_cmp_valid = 1'b0;
            unique case (in_mode)
                MODE_PUSH: begin
                    if (push_room) begin
                        ram_we  = 1'b1;
                        n_tail  = ram_waddr;
                        n_head  = empty ? '0 : r_head;
                        n_count = r_count + CNT_W'(1);
                        n_ok    = 1'b1;
                    end
                end
                MODE_POP: begin
                    if (!empty) begin
                        // the last pop empties the queue and rewinds both ends
                        n_head  = r_head + IDX_W'(1);
                        n_count = r_count - CNT_W'(1);
                        n_ok    = 1'b1;
                        if (r_count == CNT_W'(1)) begin
                            n_head = '0;
                            n_tail = '0;
                        end
                    end
                end
                MODE_FIND: begin
                    // result fixed by the scan
                end
                MODE_CLEAR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                    n_ok    = 1'b1;
                end
                default: ;
            endcase
        end

        if (r_state == S_SCAN) begin
            // issue the next read while comparing the previous one
            n_scan      = r_scan + IDX_W'(1);
            n_cmp_idx   = r_scan;
            n_cmp_valid = 1'b1;
            if (cmp_hit) begin
                n_ok  = 1'b1;
                n_pos = POS_W'(r_cmp_idx);
            end
        end

        if (r_state == S_TAIL) begin
            n_head_val = ram_rdata;
        end

        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_data  = '0;
            n_out_data[0]                        = r_ok;
            n_out_data[POS_W:1]                  = r_pos;
            n_out_data[POS_W+CNT_W:POS_W+1]      = r_count;
            n_out_data[POS_W+CNT_W+WORD_W:POS_W+CNT_W+1]
                = empty ? WORD_NONE : r_head_val;
            n_out_data[OUT_W-1:POS_W+CNT_W+WORD_W+1]
                = empty ? WORD_NONE : ram_rdata;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= CAP_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok       <= n_ok;
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_scan     <= n_scan;
        r_cmp_idx  <= n_cmp_idx;
        r_head_val <= n_head_val;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above storage depth");

    a_span_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (CNT_W'(r_tail) - CNT_W'(r_head) + CNT_W'(1) == r_count))
        else $error("head/tail span disagrees with entry count");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cmp_valid) |-> (r_cmp_idx >= r_head && r_cmp_idx <= r_tail))
        else $error("find compared a slot outside the held entries");

    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[POS_W+CNT_W:POS_W+1] == '0)
            |-> (o_m_axis_tdata[POS_W+CNT_W+WORD_W:POS_W+CNT_W+1] == WORD_NONE))
        else $error("empty queue reported a head word");

endmodule
`default_nettype wire

### dv/tb_linear_queue_with_search.sv
// Self-checking testbench for linear_queue_with_search: directed table, then random
// push/pop/find/clear traffic checked against an in-bench queue predictor.
// Depends on lqs_pkg and the RTL under src/.
`timescale 1ns / 1ps
module tb_linear_queue_with_search;
    import lqs_pkg::*;

    // Expected result, packed to match tdata from bit 0 up
    // (ok, position, count, head_value, tail_value).
    typedef struct packed {
        logic [WORD_W-1:0] tail_value;
        logic [WORD_W-1:0] head_value;
        logic [CNT_W-1:0]  count;
        logic [POS_W-1:0]  position;
        logic              ok;
    } t_result;

    typedef enum logic [1:0] {
        ROW_CFG,    // write capacity from the value column
        ROW_RUN,    // expected result from the predictor
        ROW_CHECK   // expected result typed in the row
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_mode             mode;
        logic [WORD_W-1:0] value;
        logic              ok;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  cnt;
        logic [WORD_W-1:0] head_v;
        logic [WORD_W-1:0] tail_v;
    } t_row;

    localparam int NUM_ROWS   = 27;
    localparam int NUM_BLOCKS = 6;
    localparam int BLOCK_LEN  = 155;
    localparam int DRAIN_MAX  = 50000;

    localparam t_row DIRECTED [NUM_ROWS] = '{
        // empty queue: pop and find both fail
        '{ROW_CHECK, MODE_POP,   32'h0000_0000, 1'b0, POS_NONE, 5'd0, WORD_NONE, WORD_NONE},
        '{ROW_CHECK, MODE_FIND,  32'h0000_0000, 1'b0, POS_NONE, 5'd0, WORD_NONE, WORD_NONE},
        // extremes of the word
        '{ROW_CHECK, MODE_PUSH,  32'h7FFF_FFFF, 1'b1, POS_NONE, 5'd1, 32'h7FFF_FFFF,
          32'h7FFF_FFFF},
        '{ROW_CHECK, MODE_PUSH,  32'h8000_0000, 1'b1, POS_NONE, 5'd2, 32'h7FFF_FFFF,
          32'h8000_0000},
        '{ROW_CHECK, MODE_PUSH,  32'hFFFF_FFFF, 1'b1, POS_NONE, 5'd3, 32'h7FFF_FFFF,
          32'hFFFF_FFFF},
        '{ROW_CHECK, MODE_PUSH,  32'h0000_0000, 1'b1, POS_NONE, 5'd4, 32'h7FFF_FFFF,
          32'h0000_0000},
        '{ROW_CHECK, MODE_FIND,  32'h8000_0000, 1'b1, 5'd1,     5'd4, 32'h7FFF_FFFF,
          32'h0000_0000},
        '{ROW_CHECK, MODE_FIND,  32'h1234_5678, 1'b0, POS_NONE, 5'd4, 32'h7FFF_FFFF,
          32'h0000_0000},
        '{ROW_CHECK, MODE_POP,   32'h0000_0000, 1'b1, POS_NONE, 5'd3, 32'h8000_0000,
          32'h0000_0000},
        // popped slot is no longer searched
        '{ROW_CHECK, MODE_FIND,  32'h7FFF_FFFF, 1'b0, POS_NONE, 5'd3, 32'h8000_0000,
          32'h0000_0000},
        // a key of all ones is a real match, not the empty marker
        '{ROW_CHECK, MODE_FIND,  32'hFFFF_FFFF, 1'b1, 5'd2,     5'd3, 32'h8000_0000,
          32'h0000_0000},
        '{ROW_CHECK, MODE_CLEAR, 32'h0000_0000, 1'b1, POS_NONE, 5'd0, WORD_NONE, WORD_NONE},
        // smallest capacity: full after one push, slot reused once empty
        '{ROW_CFG,   MODE_PUSH,  32'd1,         1'b0, 5'd0,     5'd0, 32'd0,     32'd0},
        '{ROW_CHECK, MODE_PUSH,  32'hA5A5_A5A5, 1'b1, POS_NONE, 5'd1, 32'hA5A5_A5A5,
          32'hA5A5_A5A5},
        '{ROW_CHECK, MODE_PUSH,  32'h5A5A_5A5A, 1'b0, POS_NONE, 5'd1, 32'hA5A5_A5A5,
          32'hA5A5_A5A5},
        '{ROW_CHECK, MODE_POP,   32'h0000_0000, 1'b1, POS_NONE, 5'd0, WORD_NONE, WORD_NONE},
        '{ROW_RUN,   MODE_PUSH,  32'h5A5A_5A5A, 1'b0, 5'd0,     5'd0, 32'd0,     32'd0},
        // capacity zero: every push fails
        '{ROW_CFG,   MODE_PUSH,  32'd0,         1'b0, 5'd0,     5'd0, 32'd0,     32'd0},
        '{ROW_RUN,   MODE_POP,   32'hFFFF_FFFF, 1'b0, 5'd0,     5'd0, 32'd0,     32'd0},
        '{ROW_CHECK, MODE_PUSH,  32'h0000_0001, 1'b0, POS_NONE, 5'd0, WORD_NONE, WORD_NONE},
        // capacity above the depth acts as the depth
        '{ROW_CFG,   MODE_PUSH,  32'd31,        1'b0, 5'd0,     5'd0, 32'd0,     32'd0},
        '{ROW_RUN,   MODE_PUSH,  32'd11,        1'b0, 5'd0,     5'd0, 32'd0,     32'd0},
        '{ROW_RUN,   MODE_PUSH,  32'd22,        1'b0, 5'd0,     5'd0, 32'd0,     32'd0},
        '{ROW_RUN,   MODE_PUSH,  32'd22,        1'b0, 5'd0,     5'd0, 32'd0,     32'd0},
        // capacity lowered below the tail: full, entries still searchable
        '{ROW_CFG,   MODE_PUSH,  32'd1,         1'b0, 5'd0,     5'd0, 32'd0,     32'd0},
        '{ROW_CHECK, MODE_PUSH,  32'd33,        1'b0, POS_NONE, 5'd3, 32'd11,    32'd22},
        '{ROW_RUN,   MODE_FIND,  32'd22,        1'b0, 5'd0,     5'd0, 32'd0,     32'd0}
    };

    // capacity and idle percentages per random block
    localparam int BLOCK_CAP     [NUM_BLOCKS] = '{16, 7, 1, 31, 3, 16};
    localparam int BLOCK_TX_IDLE [NUM_BLOCKS] = '{32, 32, 47, 47, 0, 0};
    localparam int BLOCK_RX_IDLE [NUM_BLOCKS] = '{47, 47, 32, 32, 0, 0};

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [WORD_W-1:0]   i_s_axis_tdata  = '0;   // [31:0] value
    logic [7:0]          i_s_axis_tuser  = '0;   // [1:0] mode, rest zero
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  o_m_axis_tdata;         // [0] ok, [5:1] position, [10:6] count,
                                                 // [42:11] head, [74:43] tail, rest zero
    logic                i_cfg_we        = 1'b0;
    logic [CAP_W-1:0]    i_cfg_wdata     = '0;   // capacity

    // predictor state
    logic [WORD_W-1:0] slot_word [DEPTH];
    int                head_idx = -1;
    int                tail_idx = -1;
    int                held     = 0;
    int                capacity = 16;

    t_result           results_due [$];
    logic [WORD_W-1:0] word_pool [8];
    int                mismatch_count  = 0;
    int                words_seen      = 0;
    int                tx_idle_pct     = 0;
    int                rx_idle_pct     = 0;
    int                hold_cycles_req = 0;
    int                hold_left       = 0;

    linear_queue_with_search uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Apply one operation to the predicted queue and return the word it answers.
    function automatic t_result queue_step(t_mode mode, logic [WORD_W-1:0] value);
        t_result res;
        int      cap;
        int      pos;
        res = '0;
        pos = -1;
        cap = (capacity > DEPTH) ? DEPTH : capacity;
        case (mode)
            MODE_PUSH: begin
                if (tail_idx < cap - 1) begin
                    if (held == 0) head_idx = 0;
                    tail_idx++;
                    slot_word[tail_idx] = value;
                    held++;
                    res.ok = 1'b1;
                end
            end
            MODE_POP: begin
                if (held != 0) begin
                    head_idx++;
                    held--;
                    // last entry gone: rewind to the start of the array
                    if (head_idx > tail_idx) begin
                        head_idx = -1;
                        tail_idx = -1;
                        held     = 0;
                    end
                    res.ok = 1'b1;
                end
            end
            MODE_FIND: begin
                if (held != 0) begin
                    for (int i = head_idx; i <= tail_idx; i++) begin
                        if (slot_word[i] == value) begin
                            pos    = i;
                            res.ok = 1'b1;
                            break;
                        end
                    end
                end
            end
            default: begin
                head_idx = -1;
                tail_idx = -1;
                held     = 0;
                res.ok   = 1'b1;
            end
        endcase
        res.position = pos[POS_W-1:0];
        res.count    = held[CNT_W-1:0];
        if (held == 0) begin
            res.head_value = WORD_NONE;
            res.tail_value = WORD_NONE;
        end else begin
            res.head_value = slot_word[head_idx];
            res.tail_value = slot_word[tail_idx];
        end
        return res;
    endfunction

    // Draw a word: often from a small pool so finds hit duplicates, sometimes an extreme.
    function automatic logic [WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return word_pool[$urandom_range(0, 7)];
        if (sel == 4) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return WORD_NONE;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        $display("MISMATCH word %0d %s: got %h, want %h", words_seen, what, got, want);
        mismatch_count++;
    endtask

    // Offer one word and hold it until the block takes it.
    task automatic offer_word(t_mode mode, logic [WORD_W-1:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tuser  <= {6'b0, mode};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        while (results_due.size() != 0) begin
            @(posedge i_clk);
            waited++;
            if (waited > DRAIN_MAX) begin
                $display("Mismatches found");
                $finish;
            end
        end
    endtask

    // Stop offering, let every due word come back, then write the register.
    task automatic set_capacity(int cap);
        i_s_axis_tvalid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap[CAP_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        capacity = cap;
    endtask

    // Receiver: random stalls, plus a long counted hold-off on request.
    always @(posedge i_clk) begin
        if (hold_cycles_req != 0) begin
            hold_left       = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Check every accepted result word against the oldest due one.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1) begin
            got = o_m_axis_tdata[OUT_W-1:0];
            words_seen++;
            if (o_m_axis_tdata[TDATA_W-1:OUT_W] !== '0)
                report_mismatch("padding", 32'(o_m_axis_tdata[TDATA_W-1:OUT_W]), 32'd0);
            if (results_due.size() == 0) begin
                report_mismatch("word with nothing due", 32'(got.count), 32'd0);
            end else begin
                want = results_due.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("ok", 32'(got.ok), 32'(want.ok));
                if (got.position !== want.position)
                    report_mismatch("position", 32'(got.position), 32'(want.position));
                if (got.count !== want.count)
                    report_mismatch("count", 32'(got.count), 32'(want.count));
                if (got.head_value !== want.head_value)
                    report_mismatch("head_value", got.head_value, want.head_value);
                if (got.tail_value !== want.tail_value)
                    report_mismatch("tail_value", got.tail_value, want.tail_value);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_result          want;
        t_mode            mode;
        logic [WORD_W-1:0] value;
        int               bias;
        int               roll;
        int               push_lim;
        int               pop_lim;
        int               find_lim;

        tx_idle_pct = BLOCK_TX_IDLE[0];
        rx_idle_pct = BLOCK_RX_IDLE[0];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                set_capacity(int'(DIRECTED[i].value[CAP_W-1:0]));
            end else begin
                offer_word(DIRECTED[i].mode, DIRECTED[i].value);
                want = queue_step(DIRECTED[i].mode, DIRECTED[i].value);
                if (DIRECTED[i].kind == ROW_CHECK)
                    want = '{DIRECTED[i].tail_v, DIRECTED[i].head_v, DIRECTED[i].cnt,
                             DIRECTED[i].pos, DIRECTED[i].ok};
                results_due.push_back(want);
            end
        end

        // random blocks, each under its own capacity and idle mix
        bias = 0;
        for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
            set_capacity(BLOCK_CAP[blk]);
            tx_idle_pct = BLOCK_TX_IDLE[blk];
            rx_idle_pct = BLOCK_RX_IDLE[blk];
            foreach (word_pool[k]) word_pool[k] = $urandom;
            // hold the output off long enough for the block to back up its input
            if (blk == 4) hold_cycles_req = 400;
            for (int n = 0; n < BLOCK_LEN; n++) begin
                // switch between filling, draining and mixed stretches
                if (n % 24 == 0) bias = $urandom_range(0, 2);
                case (bias)
                    0:       begin push_lim = 70; pop_lim = 80; find_lim = 97; end
                    1:       begin push_lim = 15; pop_lim = 75; find_lim = 97; end
                    default: begin push_lim = 40; pop_lim = 70; find_lim = 97; end
                endcase
                roll  = $urandom_range(0, 99);
                value = pick_word();
                if (roll < push_lim) begin
                    mode = MODE_PUSH;
                end else if (roll < pop_lim) begin
                    mode = MODE_POP;
                end else if (roll < find_lim) begin
                    mode = MODE_FIND;
                    // search mostly for words that are held
                    if (held != 0 && $urandom_range(0, 2) != 0)
                        value = slot_word[$urandom_range(head_idx, tail_idx)];
                end else begin
                    mode = MODE_CLEAR;
                end
                offer_word(mode, value);
                results_due.push_back(queue_step(mode, value));
            end
        end

        i_s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### linear_queue_with_search.f
src/lqs_pkg.sv
src/lqs_ram.sv
src/linear_queue_with_search.sv
dv/tb_linear_queue_with_search.sv
